// ----- src/md5_message_digest_macros.svh -----
// ---------------------------------------------------------------------------
// md5_message_digest_macros.svh
// Assertion macros shared by the MD5 block.
// ---------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MD5_ASSERT_R(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MD5_ASSERT(label, clk, rst, prop, msg)
`define MD5_ASSERT_R(label, clk, prop, msg)
`endif
`endif

// ----- src/md5_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables for the MD5 block.
// ---------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_rot(input logic [3:0] sel);
    logic [4:0] r;
    begin
      unique case (sel)
        4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
        4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
        4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/md5_message_digest.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per item, digest as four words.
// ---------------------------------------------------------------------------
// A byte item is taken without a stall unless it fills the 64-byte block;
// then stall stays high while the shared round unit runs 64 rounds and
// adds into the chain. An end-of-message item writes the pad and length
// bytes one per cycle, pausing for each of one or two compressions, and
// then presents the four digest words, word 0 first, each held until
// taken.
`include "md5_message_digest_macros.svh"
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5_pkg::state_t    state, state_next;
  md5_pkg::core_ctl_t ctl;
  logic [127:0] chain;
  logic [63:0]  bit_count;
  logic [63:0]  total;
  logic [2:0]   len_idx;
  logic [1:0]   oidx;
  logic         fin_pend;
  logic         lenflag;
  logic         wr_en, start, chain_init;
  logic [7:0]   wr_byte;
  logic [5:0]   pos;
  logic         in_take, out_take;
  logic         need_comp;

  assign pos      = bit_count[8:3];
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != md5_pkg::ST_IDLE);

  md5_core u_core (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_pos(pos), .wr_byte(wr_byte),
    .start(start), .chain_init(chain_init), .ctl(ctl), .chain(chain)
  );

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_byte    = data_byte;
    start      = 1'b0;
    chain_init = 1'b0;
    need_comp  = 1'b0;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (in_take) begin
          wr_en = byte_present;
          need_comp = byte_present && (pos == 6'd63);
          start = need_comp;
          if (need_comp) state_next = md5_pkg::ST_ROUND;
          else if (end_of_message) state_next = md5_pkg::ST_PAD;
        end
      end
      md5_pkg::ST_ROUND: begin
        // after a compression, return to idle, or during the finish resume padding or emit
        if (ctl.done) begin
          if (!fin_pend) state_next = md5_pkg::ST_IDLE;
          else if (lenflag) state_next = md5_pkg::ST_OUT;
          else state_next = md5_pkg::ST_PAD;
        end
      end
      md5_pkg::ST_PAD: begin
        wr_en = 1'b1;
        wr_byte = (bit_count == total) ? md5_pkg::PAD_BYTE : 8'h00;
        start = (pos == 6'd63);
        if (start) state_next = md5_pkg::ST_ROUND;
        else if (pos == md5_pkg::LEN_POS - 6'd1) state_next = md5_pkg::ST_LEN;
      end
      md5_pkg::ST_LEN: begin
        wr_en = 1'b1;
        wr_byte = total[{len_idx, 3'd0} +: 8];
        start = (len_idx == 3'd7);
        if (start) state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_OUT: begin
        if (out_take && oidx == 2'd3) begin
          chain_init = 1'b1;
          state_next = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= md5_pkg::ST_IDLE;
      bit_count <= '0;
      fin_pend  <= 1'b0;
      len_idx   <= '0;
      oidx      <= '0;
      lenflag   <= 1'b0;
      total     <= '0;
    end else begin
      state <= state_next;
      if (wr_en) bit_count <= bit_count + 64'd8;
      unique case (state)
        md5_pkg::ST_IDLE: begin
          len_idx <= '0;
          lenflag <= 1'b0;
          oidx    <= '0;
          if (in_take && end_of_message) begin
            fin_pend <= 1'b1;
            total    <= bit_count + (byte_present ? 64'd8 : 64'd0);
          end else begin
            fin_pend <= 1'b0;
          end
        end
        md5_pkg::ST_LEN: begin
          len_idx <= len_idx + 3'd1;
          if (len_idx == 3'd7) lenflag <= 1'b1;
        end
        md5_pkg::ST_OUT: begin
          if (out_take) oidx <= oidx + 2'd1;
          if (chain_init) begin
            bit_count <= '0;
            fin_pend  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == md5_pkg::ST_OUT);
  assign digest_word = chain[{oidx, 5'd0} +: 32];
  assign word_index  = oidx;
  assign last_word   = (oidx == 2'd3);

  `MD5_ASSERT(a_out_idle_core, clk, rst, out_valid |-> !ctl.busy,
              "digest shown while rounds run")
  `MD5_ASSERT(a_start_stalled, clk, rst, ctl.start |=> in_stall,
              "input open during compression")
  `MD5_ASSERT_R(a_reset_idle, clk, $past(rst) |-> !out_valid, "output after reset")

endmodule

// ----- src/md5_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_core
// One MD5 round per cycle over a 16-word block memory; adds into the chain.
// ---------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"
module md5_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [5:0]          wr_pos,
  input  logic [7:0]          wr_byte,
  input  logic                start,
  input  logic                chain_init,
  output md5_pkg::core_ctl_t  ctl,
  output logic [127:0]        chain
);

  logic [31:0] mem [16];
  logic [31:0] a, b, c, d;
  logic [31:0] ca, cb, cc, cd;
  logic [5:0]  rnd;
  logic        busy;
  logic        fin;
  logic [31:0] w_rd;
  logic [3:0]  g;
  logic [1:0]  phase;
  logic [31:0] f, t, tr;
  logic [4:0]  sh;
  logic [5:0]  rnd_next;

  assign phase = rnd[5:4];
  assign rnd_next = rnd + 6'd1;

  // word index for the next round, registered into w_rd before that round runs
  always_comb begin
    unique case (rnd_next[5:4])
      2'd0: g = rnd_next[3:0];
      2'd1: g = 4'(5 * rnd_next[3:0] + 1);
      2'd2: g = 4'(3 * rnd_next[3:0] + 5);
      default: g = 4'(7 * rnd_next[3:0]);
    endcase
  end

  // bytes land little-endian inside each 32-bit word
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_pos[5:2]][{wr_pos[1:0], 3'd0} +: 8] <= wr_byte;
    if (start) w_rd <= mem[4'd0];
    else w_rd <= mem[g];
  end

  always_comb begin
    unique case (phase)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t  = a + f + w_rd + md5_pkg::round_k(rnd);
    sh = md5_pkg::round_rot({phase, rnd[1:0]});
    tr = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd_next;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= ca; b <= cb; c <= cc; d <= cd;
    end else if (busy) begin
      a <= d; d <= c; c <= b; b <= b + tr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || chain_init) begin
      ca <= md5_pkg::IV_A; cb <= md5_pkg::IV_B;
      cc <= md5_pkg::IV_C; cd <= md5_pkg::IV_D;
    end else if (fin) begin
      ca <= ca + a; cb <= cb + b; cc <= cc + c; cd <= cd + d;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = fin;
  assign chain = {cd, cc, cb, ca};

  `MD5_ASSERT(a_no_restart, clk, rst, !(busy && start), "core restarted while busy")
  `MD5_ASSERT(a_done_after, clk, rst, fin |-> $past(busy) && $past(rnd) == 6'd63,
              "done without last round")
  `MD5_ASSERT(a_start_busy, clk, rst, start |=> busy, "start did not take")

endmodule

// ----- tb/tb_md5_message_digest.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_md5_message_digest
// Self-checking bench for the MD5 byte-stream digest block.
// ---------------------------------------------------------------------------
// Messages of random length and content go in one byte per item. A local MD5
// model digests them and queues the four expected digest words, which are
// compared with what the block emits. The sender drives bursts with random
// idle gaps and the receiver stalls at random.
module tb_md5_message_digest;

  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_message_digest dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_present(byte_present),
    .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  msg_item_t   pending_items[$];
  digest_out_t digest_expect[$];
  logic [31:0] chain[4];
  logic [7:0]  blk[64];
  logic [63:0] nbits;
  int          errors;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;
  bit          in_accepted;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic chain_init();
    chain[0] = md5_pkg::IV_A;
    chain[1] = md5_pkg::IV_B;
    chain[2] = md5_pkg::IV_C;
    chain[3] = md5_pkg::IV_D;
    nbits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t;
    int g, ph;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + w[g] + md5_pkg::round_k(i[5:0]);
      t = rotl(t, md5_pkg::round_rot({ph[1:0], i[1:0]}));
      a = d; d = c; c = b; b = b + t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    logic [5:0] pos;
    pos = nbits[8:3];
    blk[pos] = v;
    nbits += 64'd8;
    if (pos == 6'd63) compress_block();
  endtask

  // Predict digests for one accepted item.
  task automatic digest_step(input msg_item_t it);
    logic [63:0] total;
    if (it.present) absorb_byte(it.data);
    if (!it.eom) return;
    total = nbits;
    absorb_byte(md5_pkg::PAD_BYTE);
    while (nbits[8:3] != md5_pkg::LEN_POS) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(total[8*i +: 8]);
    for (int i = 0; i < 4; i++)
      digest_expect.push_back('{chain[i], i[1:0], i == 3});
    chain_init();
  endtask

  task automatic add_message(input int len, input bit last_carries);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && last_carries)
        pending_items.push_back('{8'($urandom_range(255)), 1'b1, 1'b1});
      else
        pending_items.push_back('{8'($urandom_range(255)), 1'b1, 1'b0});
    end
    if (!last_carries || len == 0)
      pending_items.push_back('{8'($urandom_range(255)), 1'b0, 1'b1});
  endtask

  // Record whether the driven item was taken at this edge.
  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && !in_stall;
  end

  // Driver: bursts of valid separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_valid) void'(pending_items.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        {data_byte, byte_present, end_of_message} <= pending_items[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (($urandom_range(15) < 4) && ($urandom_range(7) != 0)) ? 1'b1 : 1'b0;
  end

  // Monitor: predict on input accept, check on output accept.
  always @(posedge clk) begin
    digest_out_t exp_w;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        digest_step('{data_byte, byte_present, end_of_message});
      end
      if (out_valid && !out_stall) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest word %h index %0d", digest_word, word_index);
          errors++;
        end else begin
          exp_w = digest_expect.pop_front();
          if (digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, digest_word);
            errors++;
          end
          if (word_index !== exp_w.index) begin
            $error("word_index expected %0d actual %0d", exp_w.index, word_index);
            errors++;
          end
          if (last_word !== exp_w.last) begin
            $error("last_word expected %0d actual %0d", exp_w.last, last_word);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int count;
    int len;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    in_accepted = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    data_byte = '0;
    byte_present = 1'b0;
    end_of_message = 1'b0;
    chain_init();
    for (int i = 0; i < 64; i++) blk[i] = '0;

    // Directed: empty message, no-op item, byte with end, extreme bytes,
    // exact block boundary and boundaries around the length position.
    pending_items.push_back('{8'hff, 1'b0, 1'b0});
    pending_items.push_back('{8'h00, 1'b0, 1'b1});
    pending_items.push_back('{8'hff, 1'b1, 1'b1});
    pending_items.push_back('{8'h00, 1'b1, 1'b0});
    pending_items.push_back('{8'h55, 1'b1, 1'b0});
    pending_items.push_back('{8'haa, 1'b0, 1'b0});
    pending_items.push_back('{8'h00, 1'b0, 1'b1});
    add_message(64, 1'b0);
    add_message(55, 1'b1);
    add_message(56, 1'b1);
    add_message(64, 1'b1);
    add_message(120, 1'b0);

    count = 0;
    while (count < 80) begin
      case ($urandom_range(9))
        0: len = $urandom_range(130);
        1: len = 54 + $urandom_range(12);
        default: len = $urandom_range(20);
      endcase
      add_message(len, $urandom_range(1));
      if ($urandom_range(5) == 0)
        pending_items.push_back('{8'($urandom_range(255)), 1'b0, 1'b0});
      count += len + 1;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && !in_valid);
    wait (digest_expect.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_expect.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/md5_pkg.sv
src/md5_core.sv
src/md5_message_digest.sv
tb/tb_md5_message_digest.sv
